>>> rtl/core/kcv_pkg.sv
// shared types, constants and helpers of the constant-velocity kalman filter
package kcv_pkg;

    localparam int NUM_AXES   = 3;
    localparam int STATE_W    = 32;
    localparam int TS_W       = 21;
    localparam int NOISE_W    = 37;
    localparam int CFG_DATA_W = 37;
    localparam int CFG_IDX_W  = 4;
    localparam int WORD_W     = 64;
    localparam int PC_W       = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QN_POSITION   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QN_HEADING    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QN_VELOCITY   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QN_TURN_RATE  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RN_POSITION   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RN_HEADING    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VARIANCE = 4'd7;

    // register reset values
    localparam logic [TS_W-1:0]    TIME_STEP_RESET = 21'd17511;
    localparam logic [NOISE_W-1:0] QN_POS_RESET    = 37'd4294967;
    localparam logic [NOISE_W-1:0] QN_HEAD_RESET   = 37'd429497;
    localparam logic [NOISE_W-1:0] QN_VEL_RESET    = 37'd4294967;
    localparam logic [NOISE_W-1:0] QN_TURN_RESET   = 37'd42950;
    localparam logic [NOISE_W-1:0] RN_POS_RESET    = 37'd1717987;
    localparam logic [NOISE_W-1:0] RN_HEAD_RESET   = 37'd429497;
    localparam logic [NOISE_W-1:0] INIT_VAR_RESET  = 37'd4294967296;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [WORD_W-1:0] GAIN_ONE = 64'sd4294967296;

    typedef enum logic [2:0] {
        K_MAC, K_ADD, K_NEG, K_DIV, K_BR, K_END
    } t_kind;

    typedef enum logic [1:0] {
        SAT_NONE, SAT_32, SAT_COV
    } t_satm;

    typedef enum logic [5:0] {
        OPD_ZERO, OPD_ONE, OPD_DT, OPD_QP, OPD_QV, OPD_R,
        OPD_POS, OPD_VEL, OPD_Z,
        OPD_P0, OPD_P1, OPD_P2,
        OPD_PP, OPD_P01, OPD_P00, OPD_P11, OPD_S,
        OPD_K0, OPD_K1, OPD_INNOV, OPD_T, OPD_GA, OPD_GB,
        OPD_M0, OPD_M1, OPD_M2, OPD_M3,
        OPD_N00, OPD_N01, OPD_N11, OPD_KR0, OPD_KR1,
        OPD_EP, OPD_EV
    } t_opnd;

    typedef struct packed {
        t_kind kind;
        t_opnd dst;
        t_opnd a;
        t_opnd b;
        t_opnd c;
        logic  sh32;
        t_satm satm;
    } t_uop;

    typedef struct packed {
        logic [TS_W-1:0]    dt;
        logic [NOISE_W-1:0] qp;
        logic [NOISE_W-1:0] qv;
        logic [NOISE_W-1:0] r;
    } t_lane_cfg;

    typedef struct packed {
        logic                      idle;
        logic                      done;
        logic signed [STATE_W-1:0] est_pos;
        logic signed [STATE_W-1:0] est_vel;
        logic                      clip;
    } t_lane_stat;

    function automatic logic [WORD_W-1:0] kcv_mag(input logic signed [WORD_W-1:0] a);
        kcv_mag = a[WORD_W-1] ? (~a + 64'd1) : a;
    endfunction

    function automatic t_uop mk(input t_kind k, input t_opnd d, input t_opnd a,
                                input t_opnd b, input t_opnd c, input logic s32,
                                input t_satm s);
        t_uop u;
        u.kind = k;
        u.dst  = d;
        u.a    = a;
        u.b    = b;
        u.c    = c;
        u.sh32 = s32;
        u.satm = s;
        mk = u;
    endfunction

    // per-axis filter program
    function automatic t_uop kcv_uop(input logic [PC_W-1:0] pc);
        case (pc)
            5'd0:  kcv_uop = mk(K_MAC, OPD_PP,    OPD_DT,  OPD_VEL,  OPD_POS,  1'b0, SAT_32);
            5'd1:  kcv_uop = mk(K_MAC, OPD_P01,   OPD_DT,  OPD_P2,   OPD_P1,   1'b0, SAT_COV);
            5'd2:  kcv_uop = mk(K_ADD, OPD_T,     OPD_P1,  OPD_ZERO, OPD_P01,  1'b0, SAT_NONE);
            5'd3:  kcv_uop = mk(K_MAC, OPD_T,     OPD_DT,  OPD_T,    OPD_P0,   1'b0, SAT_NONE);
            5'd4:  kcv_uop = mk(K_ADD, OPD_P00,   OPD_T,   OPD_ZERO, OPD_QP,   1'b0, SAT_COV);
            5'd5:  kcv_uop = mk(K_ADD, OPD_P11,   OPD_P2,  OPD_ZERO, OPD_QV,   1'b0, SAT_COV);
            5'd6:  kcv_uop = mk(K_ADD, OPD_S,     OPD_P00, OPD_ZERO, OPD_R,    1'b0, SAT_COV);
            5'd7:  kcv_uop = mk(K_BR,  OPD_ZERO,  OPD_S,   OPD_ZERO, OPD_ZERO, 1'b0, SAT_NONE);
            5'd8:  kcv_uop = mk(K_DIV, OPD_K0,    OPD_P00, OPD_S,    OPD_ZERO, 1'b0, SAT_NONE);
            5'd9:  kcv_uop = mk(K_DIV, OPD_K1,    OPD_P01, OPD_S,    OPD_ZERO, 1'b0, SAT_NONE);
            5'd10: kcv_uop = mk(K_NEG, OPD_T,     OPD_PP,  OPD_ZERO, OPD_ZERO, 1'b0, SAT_NONE);
            5'd11: kcv_uop = mk(K_ADD, OPD_INNOV, OPD_Z,   OPD_ZERO, OPD_T,    1'b0, SAT_NONE);
            5'd12: kcv_uop = mk(K_MAC, OPD_EP,    OPD_K0,  OPD_INNOV, OPD_PP,  1'b1, SAT_32);
            5'd13: kcv_uop = mk(K_MAC, OPD_EV,    OPD_K1,  OPD_INNOV, OPD_VEL, 1'b1, SAT_32);
            5'd14: kcv_uop = mk(K_NEG, OPD_T,     OPD_K0,  OPD_ZERO, OPD_ZERO, 1'b0, SAT_NONE);
            5'd15: kcv_uop = mk(K_ADD, OPD_GA,    OPD_ONE, OPD_ZERO, OPD_T,    1'b0, SAT_NONE);
            5'd16: kcv_uop = mk(K_NEG, OPD_GB,    OPD_K1,  OPD_ZERO, OPD_ZERO, 1'b0, SAT_NONE);
            5'd17: kcv_uop = mk(K_MAC, OPD_M0,    OPD_GA,  OPD_P00,  OPD_ZERO, 1'b1, SAT_NONE);
            5'd18: kcv_uop = mk(K_MAC, OPD_M1,    OPD_GA,  OPD_P01,  OPD_ZERO, 1'b1, SAT_NONE);
            5'd19: kcv_uop = mk(K_MAC, OPD_M2,    OPD_GB,  OPD_P00,  OPD_P01,  1'b1, SAT_NONE);
            5'd20: kcv_uop = mk(K_MAC, OPD_M3,    OPD_GB,  OPD_P01,  OPD_P11,  1'b1, SAT_NONE);
            5'd21: kcv_uop = mk(K_MAC, OPD_N00,   OPD_GA,  OPD_M0,   OPD_ZERO, 1'b1, SAT_NONE);
            5'd22: kcv_uop = mk(K_MAC, OPD_N01,   OPD_GB,  OPD_M0,   OPD_M1,   1'b1, SAT_NONE);
            5'd23: kcv_uop = mk(K_MAC, OPD_N11,   OPD_GB,  OPD_M2,   OPD_M3,   1'b1, SAT_NONE);
            5'd24: kcv_uop = mk(K_MAC, OPD_KR0,   OPD_K0,  OPD_R,    OPD_ZERO, 1'b1, SAT_NONE);
            5'd25: kcv_uop = mk(K_MAC, OPD_KR1,   OPD_K1,  OPD_R,    OPD_ZERO, 1'b1, SAT_NONE);
            5'd26: kcv_uop = mk(K_MAC, OPD_P0,    OPD_K0,  OPD_KR0,  OPD_N00,  1'b1, SAT_COV);
            5'd27: kcv_uop = mk(K_MAC, OPD_P1,    OPD_K1,  OPD_KR0,  OPD_N01,  1'b1, SAT_COV);
            5'd28: kcv_uop = mk(K_MAC, OPD_P2,    OPD_K1,  OPD_KR1,  OPD_N11,  1'b1, SAT_COV);
            default: kcv_uop = mk(K_END, OPD_ZERO, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, SAT_NONE);
        endcase
    endfunction

endpackage

>>> rtl/core/kcv_in_if.sv
// input item channel: prior state and camera measurement
interface kcv_in_if import kcv_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [STATE_W-1:0] prior_x;
    logic signed [STATE_W-1:0] prior_y;
    logic signed [STATE_W-1:0] prior_heading;
    logic signed [STATE_W-1:0] prior_vx;
    logic signed [STATE_W-1:0] prior_vy;
    logic signed [STATE_W-1:0] prior_turn_rate;
    logic signed [STATE_W-1:0] meas_x;
    logic signed [STATE_W-1:0] meas_y;
    logic signed [STATE_W-1:0] meas_heading;

    modport source (output valid, prior_x, prior_y, prior_heading, prior_vx, prior_vy,
                    prior_turn_rate, meas_x, meas_y, meas_heading, input ready);
    modport sink (input valid, prior_x, prior_y, prior_heading, prior_vx, prior_vy,
                  prior_turn_rate, meas_x, meas_y, meas_heading, output ready);
endinterface

>>> rtl/core/kcv_out_if.sv
// result channel: corrected state and saturation flag
interface kcv_out_if import kcv_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [STATE_W-1:0] est_x;
    logic signed [STATE_W-1:0] est_y;
    logic signed [STATE_W-1:0] est_heading;
    logic signed [STATE_W-1:0] est_vx;
    logic signed [STATE_W-1:0] est_vy;
    logic signed [STATE_W-1:0] est_turn_rate;
    logic                      saturated;

    modport source (output valid, est_x, est_y, est_heading, est_vx, est_vy,
                    est_turn_rate, saturated, input ready);
    modport sink (input valid, est_x, est_y, est_heading, est_vx, est_vy,
                  est_turn_rate, saturated, output ready);
endinterface

>>> rtl/core/kcv_cfg_if.sv
// configuration write channel
interface kcv_cfg_if import kcv_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/kalman_constant_velocity_3axis_unit.sv
// top level of the three-axis constant-velocity kalman filter
// Three identical lanes, one per axis (x, y, heading), run side by side on each
// input transaction: predict over dt, add process noise, form the gain by two
// serial divisions, correct the state and update the covariance in joseph form.
// Each lane keeps its own 2x2 covariance block; a merge stage gathers the three
// corrected axes and the saturation flags into one output register, so a result
// can wait for the consumer while the lanes already take the next transaction.
// From acceptance to result each lane issues 17 multiplies of four 32x32
// partial-product passes, two 128-step divisions and 11 further steps, so the
// divider dominates. The input is ready again once all lanes have handed their
// results to the merge stage. Configuration writes are always accepted and are
// meant to arrive only while the block is idle; writing initial_variance reloads
// all covariance blocks.
module kalman_constant_velocity_3axis_unit import kcv_pkg::*; #(
    parameter int FRAC_BITS = 20,
    parameter int COV_WIDTH = 40
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kcv_in_if.sink    i_in,
    kcv_out_if.source o_out,
    kcv_cfg_if.sink   i_cfg
);
    // configuration registers
    logic [TS_W-1:0]    r_time_step;
    logic [NOISE_W-1:0] r_qn_pos, r_qn_head, r_qn_vel, r_qn_turn;
    logic [NOISE_W-1:0] r_rn_pos, r_rn_head;

    logic cfg_wr, cfg_load, start, take;
    t_lane_cfg  lane_cfg [NUM_AXES];
    t_lane_stat lane_stat [NUM_AXES];
    logic signed [STATE_W-1:0] pos_f [NUM_AXES];
    logic signed [STATE_W-1:0] vel_f [NUM_AXES];
    logic signed [STATE_W-1:0] z_f   [NUM_AXES];

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid & i_cfg.ready;
    assign cfg_load    = cfg_wr && (i_cfg.index == CFG_INIT_VARIANCE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RESET;
            r_qn_pos    <= QN_POS_RESET;
            r_qn_head   <= QN_HEAD_RESET;
            r_qn_vel    <= QN_VEL_RESET;
            r_qn_turn   <= QN_TURN_RESET;
            r_rn_pos    <= RN_POS_RESET;
            r_rn_head   <= RN_HEAD_RESET;
        end else if (cfg_wr) begin
            // initial variance lives in the lanes as the reloaded covariance
            case (i_cfg.index)
                CFG_TIME_STEP:    r_time_step <= i_cfg.data[TS_W-1:0];
                CFG_QN_POSITION:  r_qn_pos    <= i_cfg.data;
                CFG_QN_HEADING:   r_qn_head   <= i_cfg.data;
                CFG_QN_VELOCITY:  r_qn_vel    <= i_cfg.data;
                CFG_QN_TURN_RATE: r_qn_turn   <= i_cfg.data;
                CFG_RN_POSITION:  r_rn_pos    <= i_cfg.data;
                CFG_RN_HEADING:   r_rn_head   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // accept only when every lane is free
    assign i_in.ready = lane_stat[0].idle & lane_stat[1].idle & lane_stat[2].idle;
    assign start      = i_in.valid & i_in.ready;

    assign pos_f[0] = i_in.prior_x;
    assign pos_f[1] = i_in.prior_y;
    assign pos_f[2] = i_in.prior_heading;
    assign vel_f[0] = i_in.prior_vx;
    assign vel_f[1] = i_in.prior_vy;
    assign vel_f[2] = i_in.prior_turn_rate;
    assign z_f[0]   = i_in.meas_x;
    assign z_f[1]   = i_in.meas_y;
    assign z_f[2]   = i_in.meas_heading;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        // x and y share position noise, heading has its own
        assign lane_cfg[g].dt = r_time_step;
        assign lane_cfg[g].qp = (g < 2) ? r_qn_pos : r_qn_head;
        assign lane_cfg[g].qv = (g < 2) ? r_qn_vel : r_qn_turn;
        assign lane_cfg[g].r  = (g < 2) ? r_rn_pos : r_rn_head;

        kcv_lane #(.FRAC_BITS(FRAC_BITS), .COV_WIDTH(COV_WIDTH)) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (start),
            .i_pos      (pos_f[g]),
            .i_vel      (vel_f[g]),
            .i_z        (z_f[g]),
            .i_cfg      (lane_cfg[g]),
            .i_load     (cfg_load),
            .i_load_val (i_cfg.data),
            .i_take     (take),
            .o_stat     (lane_stat[g])
        );
    end

    kcv_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (lane_stat),
        .o_take  (take),
        .o_out   (o_out)
    );
endmodule

>>> rtl/core/kcv_mul.sv
// multi-cycle 64x64 signed multiply with rounding shift and saturation
module kcv_mul import kcv_pkg::*; #(
    parameter int FRAC_BITS = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [WORD_W-1:0] i_a,
    input  logic signed [WORD_W-1:0] i_b,
    input  logic                     i_sh32,
    output logic                     o_done,
    output logic signed [WORD_W-1:0] o_res,
    output logic                     o_clip
);
    typedef enum logic [1:0] {M_IDLE, M_ACC, M_RND, M_SHF} t_mstate;

    localparam logic [2*WORD_W-1:0] RND_FB = 128'd1 << (FRAC_BITS - 1);
    localparam logic [2*WORD_W-1:0] RND_32 = 128'd1 << 31;

    t_mstate             r_state;
    logic [1:0]          r_cnt;
    logic [WORD_W-1:0]   r_ua, r_ub;
    logic                r_neg, r_sh32;
    logic [2*WORD_W-1:0] r_acc;
    logic                r_done;
    logic signed [WORD_W-1:0] r_res;
    logic                r_clip;

    logic [31:0]         ha, hb;
    logic [63:0]         pp;
    logic [2*WORD_W-1:0] pp_sh;
    logic [2*WORD_W-1:0] signed_prod;
    logic signed [2*WORD_W-1:0] shifted;
    logic                fits;

    always_comb begin
        ha = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
        hb = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];
        pp = ha * hb;
        case (r_cnt)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        signed_prod = r_neg ? (~r_acc + 128'd1) : r_acc;
        shifted = r_sh32 ? ($signed(r_acc) >>> 32) : ($signed(r_acc) >>> FRAC_BITS);
        fits = (&shifted[127:63]) | ~(|shifted[127:63]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_ua    <= kcv_mag(i_a);
                        r_ub    <= kcv_mag(i_b);
                        r_neg   <= i_a[WORD_W-1] ^ i_b[WORD_W-1];
                        r_sh32  <= i_sh32;
                        r_acc   <= '0;
                        r_cnt   <= 2'd0;
                        r_state <= M_ACC;
                    end
                end
                M_ACC: begin
                    r_acc <= r_acc + pp_sh;
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) r_state <= M_RND;
                end
                M_RND: begin
                    r_acc   <= signed_prod + (r_sh32 ? RND_32 : RND_FB);
                    r_state <= M_SHF;
                end
                M_SHF: begin
                    // result must fit 64 signed bits, else clip to the product's sign
                    r_res   <= fits ? shifted[63:0] : (r_acc[127] ? WORD_MIN : WORD_MAX);
                    r_clip  <= ~fits;
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_clip = r_clip;
endmodule

>>> rtl/core/kcv_div.sv
// serial q32 divider, rounds half away from zero, saturates to 64 bits
module kcv_div import kcv_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [WORD_W-1:0] i_num,
    input  logic signed [WORD_W-1:0] i_den,
    output logic                     o_done,
    output logic signed [WORD_W-1:0] o_res,
    output logic                     o_clip
);
    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} t_dstate;

    localparam logic [WORD_W-1:0] HALF_RANGE = 64'h8000_0000_0000_0000;

    t_dstate             r_state;
    logic [6:0]          r_cnt;
    logic [2*WORD_W-1:0] r_dvd;
    logic [WORD_W-1:0]   r_rem, r_q, r_den;
    logic                r_ovf, r_neg;
    logic                r_done;
    logic signed [WORD_W-1:0] r_res;
    logic                r_clip;

    logic [WORD_W:0]     rem_sh;
    logic [WORD_W:0]     diff;
    logic                ge;
    logic [WORD_W-1:0]   mag_num;

    always_comb begin
        rem_sh  = {r_rem, r_dvd[2*WORD_W-1]};
        diff    = rem_sh - {1'b0, r_den};
        ge      = ~diff[WORD_W];
        mag_num = kcv_mag(i_num);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= 7'd0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_dvd   <= {32'd0, mag_num, 32'd0} + {65'd0, i_den[WORD_W-1:1]};
                        r_den   <= i_den;
                        r_neg   <= i_num[WORD_W-1];
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_ovf   <= 1'b0;
                        r_cnt   <= 7'd0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_dvd <= {r_dvd[2*WORD_W-2:0], 1'b0};
                    r_rem <= ge ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
                    r_q   <= {r_q[WORD_W-2:0], ge};
                    // a quotient bit shifted out above bit 63 is an overflow
                    r_ovf <= r_ovf | r_q[WORD_W-1];
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) r_state <= D_FIN;
                end
                D_FIN: begin
                    if (r_neg) begin
                        if (r_ovf || (r_q > HALF_RANGE)) begin
                            r_res  <= WORD_MIN;
                            r_clip <= 1'b1;
                        end else begin
                            r_res  <= ~r_q + 64'd1;
                            r_clip <= 1'b0;
                        end
                    end else begin
                        if (r_ovf || r_q[WORD_W-1]) begin
                            r_res  <= WORD_MAX;
                            r_clip <= 1'b1;
                        end else begin
                            r_res  <= r_q;
                            r_clip <= 1'b0;
                        end
                    end
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_clip = r_clip;
endmodule

>>> rtl/core/kcv_lane.sv
// one axis lane: sequencer over its own multiplier and divider, holds its 2x2 covariance
module kcv_lane import kcv_pkg::*; #(
    parameter int FRAC_BITS = 20,
    parameter int COV_WIDTH = 40
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [STATE_W-1:0] i_pos,
    input  logic signed [STATE_W-1:0] i_vel,
    input  logic signed [STATE_W-1:0] i_z,
    input  t_lane_cfg                 i_cfg,
    input  logic                      i_load,
    input  logic [NOISE_W-1:0]        i_load_val,
    input  logic                      i_take,
    output t_lane_stat                o_stat
);
    typedef enum logic [2:0] {L_IDLE, L_ISSUE, L_MULW, L_DIVW, L_WB, L_DONE} t_lstate;

    localparam logic [WORD_W:0] COV_MAX = (65'd1 << (COV_WIDTH - 1)) - 65'd1;
    localparam logic signed [WORD_W-1:0] COV_INIT =
        ({28'd0, INIT_VAR_RESET} > COV_MAX) ? COV_MAX[WORD_W-1:0]
                                            : {27'd0, INIT_VAR_RESET};

    t_lstate          r_state;
    logic [PC_W-1:0]  r_pc;
    logic             r_clip;
    logic signed [STATE_W-1:0] r_pos, r_vel, r_z;
    logic signed [WORD_W-1:0]  r_x;
    logic signed [WORD_W-1:0]  r_p0, r_p1, r_p2;
    logic signed [WORD_W-1:0]  r_pp, r_p01, r_p00, r_p11, r_s;
    logic signed [WORD_W-1:0]  r_k0, r_k1, r_innov, r_t, r_ga, r_gb;
    logic signed [WORD_W-1:0]  r_m0, r_m1, r_m2, r_m3, r_n00, r_n01, r_n11;
    logic signed [WORD_W-1:0]  r_kr0, r_kr1, r_ep, r_ev;

    t_uop uop;
    logic signed [WORD_W-1:0] opa, opb, opc;
    logic signed [WORD_W-1:0] add_a, add_y, sat_y, neg_y, w_val, load_cov;
    logic signed [WORD_W:0]   sum;
    logic add_ovf, fits32, fitscov, neg_clip, sat_clip;
    logic w_en, w_clip;
    logic mul_start, mul_done, mul_clip, div_start, div_done, div_clip;
    logic signed [WORD_W-1:0] mul_res, div_res;

    function automatic logic signed [WORD_W-1:0] sel(input t_opnd o);
        case (o)
            OPD_ONE:   sel = GAIN_ONE;
            OPD_DT:    sel = {43'd0, i_cfg.dt};
            OPD_QP:    sel = {27'd0, i_cfg.qp};
            OPD_QV:    sel = {27'd0, i_cfg.qv};
            OPD_R:     sel = {27'd0, i_cfg.r};
            OPD_POS:   sel = {{32{r_pos[STATE_W-1]}}, r_pos};
            OPD_VEL:   sel = {{32{r_vel[STATE_W-1]}}, r_vel};
            OPD_Z:     sel = {{32{r_z[STATE_W-1]}}, r_z};
            OPD_P0:    sel = r_p0;
            OPD_P1:    sel = r_p1;
            OPD_P2:    sel = r_p2;
            OPD_PP:    sel = r_pp;
            OPD_P01:   sel = r_p01;
            OPD_P00:   sel = r_p00;
            OPD_P11:   sel = r_p11;
            OPD_S:     sel = r_s;
            OPD_K0:    sel = r_k0;
            OPD_K1:    sel = r_k1;
            OPD_INNOV: sel = r_innov;
            OPD_T:     sel = r_t;
            OPD_GA:    sel = r_ga;
            OPD_GB:    sel = r_gb;
            OPD_M0:    sel = r_m0;
            OPD_M1:    sel = r_m1;
            OPD_M2:    sel = r_m2;
            OPD_M3:    sel = r_m3;
            OPD_N00:   sel = r_n00;
            OPD_N01:   sel = r_n01;
            OPD_N11:   sel = r_n11;
            OPD_KR0:   sel = r_kr0;
            OPD_KR1:   sel = r_kr1;
            OPD_EP:    sel = r_ep;
            OPD_EV:    sel = r_ev;
            default:   sel = '0;
        endcase
    endfunction

    always_comb begin
        uop = kcv_uop(r_pc);
        opa = sel(uop.a);
        opb = sel(uop.b);
        opc = sel(uop.c);

        // saturating 64-bit add
        add_a   = (r_state == L_WB) ? r_x : opa;
        sum     = {add_a[WORD_W-1], add_a} + {opc[WORD_W-1], opc};
        add_ovf = sum[WORD_W] ^ sum[WORD_W-1];
        add_y   = add_ovf ? (sum[WORD_W] ? WORD_MIN : WORD_MAX) : sum[WORD_W-1:0];

        fits32  = (&add_y[63:31]) | ~(|add_y[63:31]);
        fitscov = (&add_y[63:COV_WIDTH-1]) | ~(|add_y[63:COV_WIDTH-1]);
        case (uop.satm)
            SAT_32: begin
                sat_y    = fits32 ? add_y : {{33{add_y[63]}}, {31{~add_y[63]}}};
                sat_clip = ~fits32;
            end
            SAT_COV: begin
                sat_y    = fitscov ? add_y
                         : {{(65-COV_WIDTH){add_y[63]}}, {(COV_WIDTH-1){~add_y[63]}}};
                sat_clip = ~fitscov;
            end
            default: begin
                sat_y    = add_y;
                sat_clip = 1'b0;
            end
        endcase

        neg_clip = (opa == WORD_MIN);
        neg_y    = neg_clip ? WORD_MAX : (~opa + 64'd1);

        mul_start = (r_state == L_ISSUE) && (uop.kind == K_MAC);
        div_start = (r_state == L_ISSUE) && (uop.kind == K_DIV);

        w_en   = 1'b0;
        w_val  = sat_y;
        w_clip = 1'b0;
        case (r_state)
            L_ISSUE: begin
                if (uop.kind == K_ADD) begin
                    w_en   = 1'b1;
                    w_clip = add_ovf | sat_clip;
                end else if (uop.kind == K_NEG) begin
                    w_en   = 1'b1;
                    w_val  = neg_y;
                    w_clip = neg_clip;
                end
            end
            L_WB: begin
                w_en   = 1'b1;
                w_clip = add_ovf | sat_clip;
            end
            L_DIVW: begin
                w_en   = div_done;
                w_val  = div_res;
                w_clip = div_done & div_clip;
            end
            default: ;
        endcase

        // reload value: new initial variance saturated to covariance width
        load_cov = ({28'd0, i_load_val} > COV_MAX) ? COV_MAX[WORD_W-1:0]
                                                   : {27'd0, i_load_val};
    end

    kcv_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (opa),
        .i_b     (opb),
        .i_sh32  (uop.sh32),
        .o_done  (mul_done),
        .o_res   (mul_res),
        .o_clip  (mul_clip)
    );

    kcv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (opa),
        .i_den   (opb),
        .o_done  (div_done),
        .o_res   (div_res),
        .o_clip  (div_clip)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_pc    <= '0;
            r_clip  <= 1'b0;
            r_p0    <= COV_INIT;
            r_p1    <= '0;
            r_p2    <= COV_INIT;
        end else begin
            if (w_en) begin
                case (uop.dst)
                    OPD_P0:    r_p0    <= w_val;
                    OPD_P1:    r_p1    <= w_val;
                    OPD_P2:    r_p2    <= w_val;
                    OPD_PP:    r_pp    <= w_val;
                    OPD_P01:   r_p01   <= w_val;
                    OPD_P00:   r_p00   <= w_val;
                    OPD_P11:   r_p11   <= w_val;
                    OPD_S:     r_s     <= w_val;
                    OPD_K0:    r_k0    <= w_val;
                    OPD_K1:    r_k1    <= w_val;
                    OPD_INNOV: r_innov <= w_val;
                    OPD_T:     r_t     <= w_val;
                    OPD_GA:    r_ga    <= w_val;
                    OPD_GB:    r_gb    <= w_val;
                    OPD_M0:    r_m0    <= w_val;
                    OPD_M1:    r_m1    <= w_val;
                    OPD_M2:    r_m2    <= w_val;
                    OPD_M3:    r_m3    <= w_val;
                    OPD_N00:   r_n00   <= w_val;
                    OPD_N01:   r_n01   <= w_val;
                    OPD_N11:   r_n11   <= w_val;
                    OPD_KR0:   r_kr0   <= w_val;
                    OPD_KR1:   r_kr1   <= w_val;
                    OPD_EP:    r_ep    <= w_val;
                    OPD_EV:    r_ev    <= w_val;
                    default: ;
                endcase
                r_clip <= r_clip | w_clip;
                r_pc   <= r_pc + 5'd1;
            end
            if (i_load) begin
                r_p0 <= load_cov;
                r_p1 <= '0;
                r_p2 <= load_cov;
            end
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_pos   <= i_pos;
                        r_vel   <= i_vel;
                        r_z     <= i_z;
                        r_pc    <= '0;
                        r_clip  <= 1'b0;
                        r_state <= L_ISSUE;
                    end
                end
                L_ISSUE: begin
                    case (uop.kind)
                        K_MAC: r_state <= L_MULW;
                        K_DIV: r_state <= L_DIVW;
                        K_BR: begin
                            // no usable innovation variance: keep prediction
                            if (r_s[WORD_W-1] || (r_s == '0)) begin
                                r_clip  <= 1'b1;
                                r_p0    <= r_p00;
                                r_p1    <= r_p01;
                                r_p2    <= r_p11;
                                r_ep    <= r_pp;
                                r_ev    <= {{32{r_vel[STATE_W-1]}}, r_vel};
                                r_state <= L_DONE;
                            end else begin
                                r_pc <= r_pc + 5'd1;
                            end
                        end
                        K_END:   r_state <= L_DONE;
                        default: ;
                    endcase
                end
                L_MULW: begin
                    if (mul_done) begin
                        r_x     <= mul_res;
                        r_clip  <= r_clip | mul_clip;
                        r_state <= L_WB;
                    end
                end
                L_WB:   r_state <= L_ISSUE;
                L_DIVW: begin
                    if (div_done) r_state <= L_ISSUE;
                end
                L_DONE: begin
                    if (i_take) r_state <= L_IDLE;
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_stat.idle    = (r_state == L_IDLE);
    assign o_stat.done    = (r_state == L_DONE);
    assign o_stat.est_pos = r_ep[STATE_W-1:0];
    assign o_stat.est_vel = r_ev[STATE_W-1:0];
    assign o_stat.clip    = r_clip;
endmodule

>>> rtl/core/kcv_merge.sv
// merges the three lane results into the output register
module kcv_merge import kcv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_lane_stat i_stat [NUM_AXES],
    output logic       o_take,
    kcv_out_if.source  o_out
);
    logic r_valid;
    logic signed [STATE_W-1:0] r_x, r_y, r_h, r_vx, r_vy, r_vh;
    logic r_sat;
    logic all_done;

    assign all_done = i_stat[0].done & i_stat[1].done & i_stat[2].done;
    assign o_take   = all_done & (~r_valid | o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_valid <= 1'b1;
                r_x     <= i_stat[0].est_pos;
                r_y     <= i_stat[1].est_pos;
                r_h     <= i_stat[2].est_pos;
                r_vx    <= i_stat[0].est_vel;
                r_vy    <= i_stat[1].est_vel;
                r_vh    <= i_stat[2].est_vel;
                r_sat   <= i_stat[0].clip | i_stat[1].clip | i_stat[2].clip;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.est_x         = r_x;
    assign o_out.est_y         = r_y;
    assign o_out.est_heading   = r_h;
    assign o_out.est_vx        = r_vx;
    assign o_out.est_vy        = r_vy;
    assign o_out.est_turn_rate = r_vh;
    assign o_out.saturated     = r_sat;
endmodule
